>>> rtl/dmc_pkg.sv
// Package for the direct-mapped cache hit counter.
// Holds shared constants, register codes, state codes and control structs.
// No dependencies.
`default_nettype none

package dmc_pkg;

    localparam int MAX_SETS_DEF  = 512;
    localparam int ADDR_BITS_DEF = 32;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int BLOCK_BYTES_W = 17;
    localparam int SET_COUNT_W   = 10;

    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RST = 17'd16;
    localparam logic [SET_COUNT_W-1:0]   SET_COUNT_RST   = 10'd512;

    typedef enum logic {
        REG_BLOCK_BYTES = 1'b0,
        REG_SET_COUNT   = 1'b1
    } dmc_reg_t;

    typedef struct packed {
        logic [BLOCK_BYTES_W-1:0] block_bytes;
        logic [SET_COUNT_W-1:0]   set_count;
    } dmc_cfg_t;

    typedef struct packed {
        logic clear;
        logic fill;
    } dmc_store_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_CMP   = 4'b1000
    } dmc_state_t;

endpackage

`default_nettype wire

>>> rtl/direct_mapped_cache_hit_counter_core.sv
// Top level of the direct-mapped cache hit counter.
// Uses dmc_pkg, dmc_cfg, dmc_divmod and dmc_store.
//
// One item is processed at a time. An accepted item goes through the divider
// and then the compare state, which waits while a stalled result holds the
// output register, to its result there. The bit-serial divider forms one
// quotient bit per cycle and steps the set index remainder with it. An item
// with new_run set first runs a clearing pass over the valid memory. After
// reset the same pass runs with access_stall high. A new item is accepted
// while the previous result still waits in the output register.
`default_nettype none

module direct_mapped_cache_hit_counter_core
#(
    parameter int MAX_SETS  = dmc_pkg::MAX_SETS_DEF,
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dmc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dmc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dmc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           access_valid,
    output logic                                access_stall,
    input  wire logic [ADDR_BITS-1:0]           access_address,
    input  wire logic                           new_run,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic                                is_hit,
    output logic [63:0]                         hits_so_far,
    output logic [63:0]                         misses_so_far
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    dmc_pkg::dmc_cfg_t        cfg;
    dmc_pkg::dmc_store_ctrl_t store_ctrl;
    dmc_pkg::dmc_state_t      state_reg;
    dmc_pkg::dmc_state_t      state_next;

    logic                 pend_reg;
    logic                 pend_next;
    logic [SET_W-1:0]     clr_cnt_reg;
    logic [SET_W-1:0]     clr_cnt_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [63:0]          hit_total_reg;
    logic [63:0]          hit_total_next;
    logic [63:0]          miss_total_reg;
    logic [63:0]          miss_total_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 res_hit_reg;
    logic                 res_hit_next;
    logic [63:0]          res_hits_reg;
    logic [63:0]          res_hits_next;
    logic [63:0]          res_misses_reg;
    logic [63:0]          res_misses_next;

    logic                 accept;
    logic                 out_free;
    logic                 hit;
    logic                 clr_last;
    logic                 div_start;
    logic [ADDR_BITS-1:0] div_dividend;
    logic                 div_done;
    logic [ADDR_BITS-1:0] quotient;
    logic [SET_W-1:0]     set_index;
    logic                 rd_valid;
    logic [ADDR_BITS-1:0] rd_tag;

    assign pready = 1'b1;

    dmc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dmc_divmod
    #(
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS),
        .SET_W     (SET_W)
    )
    u_divmod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .cfg      (cfg),
        .done     (div_done),
        .quotient (quotient),
        .index    (set_index)
    );

    dmc_store
    #(
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS),
        .SET_W     (SET_W)
    )
    u_store
    (
        .clk      (clk),
        .ctrl     (store_ctrl),
        .waddr    (store_ctrl.clear ? clr_cnt_reg : set_index),
        .wtag     (quotient),
        .raddr    (set_index),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag)
    );

    assign accept       = access_valid && (state_reg == dmc_pkg::ST_IDLE);
    assign out_free     = !res_valid_reg || !result_stall;
    assign hit          = rd_valid && (rd_tag == quotient);
    assign clr_last     = clr_cnt_reg == SET_W'(MAX_SETS - 1);
    assign div_start    = (accept && !new_run)
                          || ((state_reg == dmc_pkg::ST_CLEAR) && clr_last && pend_reg);
    assign div_dividend = (state_reg == dmc_pkg::ST_IDLE) ? access_address : addr_reg;

    assign store_ctrl.clear = state_reg == dmc_pkg::ST_CLEAR;
    assign store_ctrl.fill  = (state_reg == dmc_pkg::ST_CMP) && out_free && !hit;

    always_comb
    begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        clr_cnt_next    = clr_cnt_reg;
        addr_next       = addr_reg;
        hit_total_next  = hit_total_reg;
        miss_total_next = miss_total_reg;
        res_valid_next  = res_valid_reg;
        res_hit_next    = res_hit_reg;
        res_hits_next   = res_hits_reg;
        res_misses_next = res_misses_reg;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            dmc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    clr_cnt_next = '0;
                    pend_next    = 1'b0;
                    state_next   = pend_reg ? dmc_pkg::ST_DIV : dmc_pkg::ST_IDLE;
                end
            end
            dmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = access_address;
                    if (new_run)
                    begin
                        hit_total_next  = '0;
                        miss_total_next = '0;
                        pend_next       = 1'b1;
                        state_next      = dmc_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = dmc_pkg::ST_DIV;
                    end
                end
            end
            dmc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = dmc_pkg::ST_CMP;
                end
            end
            dmc_pkg::ST_CMP:
            begin
                if (out_free)
                begin
                    if (hit)
                    begin
                        hit_total_next = hit_total_reg + 64'd1;
                        res_hits_next  = hit_total_reg + 64'd1;
                        res_misses_next = miss_total_reg;
                    end
                    else
                    begin
                        miss_total_next = miss_total_reg + 64'd1;
                        res_hits_next   = hit_total_reg;
                        res_misses_next = miss_total_reg + 64'd1;
                    end
                    res_hit_next   = hit;
                    res_valid_next = 1'b1;
                    state_next     = dmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dmc_pkg::ST_CLEAR;
            pend_reg       <= 1'b0;
            clr_cnt_reg    <= '0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            clr_cnt_reg    <= clr_cnt_next;
            hit_total_reg  <= hit_total_next;
            miss_total_reg <= miss_total_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        res_hit_reg    <= res_hit_next;
        res_hits_reg   <= res_hits_next;
        res_misses_reg <= res_misses_next;
    end

    assign access_stall  = state_reg != dmc_pkg::ST_IDLE;
    assign result_valid  = res_valid_reg;
    assign is_hit        = res_hit_reg;
    assign hits_so_far   = res_hits_reg;
    assign misses_so_far = res_misses_reg;

endmodule

`default_nettype wire

>>> rtl/dmc_cfg.sv
// Configuration registers of the cache hit counter behind an APB-style port.
// Depends on dmc_pkg for register codes, widths and reset values.
`default_nettype none

module dmc_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [dmc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [dmc_pkg::APB_DATA_W-1:0]    prdata,
    output dmc_pkg::dmc_cfg_t                      cfg
);

    logic [dmc_pkg::BLOCK_BYTES_W-1:0] block_bytes_reg;
    logic [dmc_pkg::BLOCK_BYTES_W-1:0] block_bytes_next;
    logic [dmc_pkg::SET_COUNT_W-1:0]   set_count_reg;
    logic [dmc_pkg::SET_COUNT_W-1:0]   set_count_next;
    logic                              wr_en;
    dmc_pkg::dmc_reg_t                 reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = dmc_pkg::dmc_reg_t'(paddr[2]);

    always_comb
    begin
        block_bytes_next = block_bytes_reg;
        set_count_next   = set_count_reg;
        prdata           = '0;
        unique case (reg_sel)
            dmc_pkg::REG_BLOCK_BYTES:
            begin
                prdata = {{(dmc_pkg::APB_DATA_W-dmc_pkg::BLOCK_BYTES_W){1'b0}}, block_bytes_reg};
                if (wr_en)
                begin
                    block_bytes_next = pwdata[dmc_pkg::BLOCK_BYTES_W-1:0];
                end
            end
            dmc_pkg::REG_SET_COUNT:
            begin
                prdata = {{(dmc_pkg::APB_DATA_W-dmc_pkg::SET_COUNT_W){1'b0}}, set_count_reg};
                if (wr_en)
                begin
                    set_count_next = pwdata[dmc_pkg::SET_COUNT_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= dmc_pkg::BLOCK_BYTES_RST;
            set_count_reg   <= dmc_pkg::SET_COUNT_RST;
        end
        else
        begin
            block_bytes_reg <= block_bytes_next;
            set_count_reg   <= set_count_next;
        end
    end

    assign cfg.block_bytes = block_bytes_reg;
    assign cfg.set_count   = set_count_reg;

endmodule

`default_nettype wire

>>> rtl/dmc_divmod.sv
// Bit-serial divider: block number = address / block size, and set index =
// block number mod set count, one quotient bit per cycle. Depends on dmc_pkg.
`default_nettype none

module dmc_divmod
#(
    parameter int MAX_SETS  = dmc_pkg::MAX_SETS_DEF,
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [ADDR_BITS-1:0] dividend,
    input  wire dmc_pkg::dmc_cfg_t    cfg,
    output logic                      done,
    output logic [ADDR_BITS-1:0]      quotient,
    output logic [SET_W-1:0]          index
);

    localparam int CNT_W = $clog2(ADDR_BITS);
    localparam int BB_W  = dmc_pkg::BLOCK_BYTES_W;

    logic [ADDR_BITS-1:0] a_reg;
    logic [ADDR_BITS-1:0] a_next;
    logic [ADDR_BITS-1:0] q_reg;
    logic [ADDR_BITS-1:0] q_next;
    logic [BB_W-1:0]      rem1_reg;
    logic [BB_W-1:0]      rem1_next;
    logic [SET_W-1:0]     rem2_reg;
    logic [SET_W-1:0]     rem2_next;
    logic [BB_W-1:0]      div_reg;
    logic [BB_W-1:0]      div_next;
    logic [SET_W:0]       sets_reg;
    logic [SET_W:0]       sets_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [BB_W:0]        trial1;
    logic                 qbit;
    logic [SET_W:0]       trial2;
    logic                 ge2;
    logic [SET_W:0]       sets_eff;

    always_comb
    begin
        if (cfg.set_count == '0)
        begin
            sets_eff = (SET_W+1)'(1);
        end
        else if (32'(cfg.set_count) > 32'(MAX_SETS))
        begin
            sets_eff = (SET_W+1)'(MAX_SETS);
        end
        else
        begin
            sets_eff = (SET_W+1)'(cfg.set_count);
        end
    end

    assign trial1 = {rem1_reg, a_reg[ADDR_BITS-1]};
    assign qbit   = trial1 >= {1'b0, div_reg};
    assign trial2 = {rem2_reg, qbit};
    assign ge2    = trial2 >= sets_reg;

    always_comb
    begin
        a_next    = a_reg;
        q_next    = q_reg;
        rem1_next = rem1_reg;
        rem2_next = rem2_reg;
        div_next  = div_reg;
        sets_next = sets_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = dividend;
            q_next    = '0;
            rem1_next = '0;
            rem2_next = '0;
            div_next  = (cfg.block_bytes == '0) ? BB_W'(1) : cfg.block_bytes;
            sets_next = sets_eff;
            cnt_next  = CNT_W'(ADDR_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next    = {a_reg[ADDR_BITS-2:0], 1'b0};
            q_next    = {q_reg[ADDR_BITS-2:0], qbit};
            rem1_next = qbit ? BB_W'(trial1 - {1'b0, div_reg}) : trial1[BB_W-1:0];
            rem2_next = ge2 ? SET_W'(trial2 - sets_reg) : trial2[SET_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        q_reg    <= q_next;
        rem1_reg <= rem1_next;
        rem2_reg <= rem2_next;
        div_reg  <= div_next;
        sets_reg <= sets_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign index    = rem2_reg;

endmodule

`default_nettype wire

>>> rtl/dmc_store.sv
// Tag and valid memories of the cache, with a registered read.
// Depends on dmc_pkg for the store control struct.
`default_nettype none

module dmc_store
#(
    parameter int MAX_SETS  = dmc_pkg::MAX_SETS_DEF,
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
)
(
    input  wire logic                    clk,
    input  wire dmc_pkg::dmc_store_ctrl_t ctrl,
    input  wire logic [SET_W-1:0]        waddr,
    input  wire logic [ADDR_BITS-1:0]    wtag,
    input  wire logic [SET_W-1:0]        raddr,
    output logic                         rd_valid,
    output logic [ADDR_BITS-1:0]         rd_tag
);

    logic                 valid_mem [MAX_SETS];
    logic [ADDR_BITS-1:0] tag_mem   [MAX_SETS];
    logic                 rd_valid_reg;
    logic [ADDR_BITS-1:0] rd_tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            valid_mem[waddr] <= 1'b0;
        end
        else if (ctrl.fill)
        begin
            valid_mem[waddr] <= 1'b1;
        end
        rd_valid_reg <= valid_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fill)
        begin
            tag_mem[waddr] <= wtag;
        end
        rd_tag_reg <= tag_mem[raddr];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_tag   = rd_tag_reg;

endmodule

`default_nettype wire

>>> rtl/dmc_checker.sv
// Port-level checker for the cache hit counter, bound to the top level.
// Depends on direct_mapped_cache_hit_counter_core and dmc_pkg.
`default_nettype none

module dmc_checker
#(
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 access_valid,
    input wire logic                 access_stall,
    input wire logic [ADDR_BITS-1:0] access_address,
    input wire logic                 new_run,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire logic                 is_hit,
    input wire logic [63:0]          hits_so_far,
    input wire logic [63:0]          misses_so_far
);

    a_access_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (access_valid && access_stall) |=>
            (access_valid && $stable(access_address) && $stable(new_run)))
        else $error("Stalled access item changed.");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(is_hit) && $stable(hits_so_far)
             && $stable(misses_so_far)))
        else $error("Stalled result item changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (access_valid && !access_stall) |=> access_stall)
        else $error("Block took a second item without processing the first.");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(access_stall))
        else $error("Result appeared without an item in process.");

    a_count_includes_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_hit ? (hits_so_far != 64'd0) : (misses_so_far != 64'd0)))
        else $error("Reported count does not include the current item.");

endmodule

bind direct_mapped_cache_hit_counter_core dmc_checker
#(
    .ADDR_BITS (ADDR_BITS)
)
u_dmc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .access_valid   (access_valid),
    .access_stall   (access_stall),
    .access_address (access_address),
    .new_run        (new_run),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .is_hit         (is_hit),
    .hits_so_far    (hits_so_far),
    .misses_so_far  (misses_so_far)
);

`default_nettype wire

>>> test/dmc_hit_checker.sv
`timescale 1ns / 1ps
// Checker for the direct-mapped cache hit counter: mirrors the cache lines and
// the running totals, and compares every result item with the predicted one.
// Depends on dmc_pkg for the register codes, field widths and reset values.
module dmc_hit_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dmc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dmc_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           access_valid,
    input  logic                           access_stall,
    input  logic [31:0]                    access_address,
    input  logic                           new_run,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  logic                           is_hit,
    input  logic [63:0]                    hits_so_far,
    input  logic [63:0]                    misses_so_far,
    output int                             mismatch_count,
    output int                             pending_lookups
);
    import dmc_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [63:0] hits;
        logic [63:0] misses;
    } lookup_t;

    lookup_t                  expected_lookups [$];
    logic [BLOCK_BYTES_W-1:0] block_bytes_reg;
    logic [SET_COUNT_W-1:0]   set_count_reg;
    logic [31:0]              tag_mem [MAX_SETS_DEF];
    logic [MAX_SETS_DEF-1:0]  line_valid;
    logic [63:0]              hit_total;
    logic [63:0]              miss_total;

    always @(posedge clk or negedge rst_n)
    begin : predict
        logic [31:0] divisor;
        logic [31:0] sets;
        logic [31:0] block_num;
        logic [31:0] index;
        logic        hit;
        lookup_t     seen;
        lookup_t     want;
        if (!rst_n)
        begin
            block_bytes_reg = BLOCK_BYTES_RST;
            set_count_reg   = SET_COUNT_RST;
            line_valid      = '0;
            hit_total       = '0;
            miss_total      = '0;
            expected_lookups.delete();
            pending_lookups = 0;
            mismatch_count  = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                seen = {is_hit, hits_so_far, misses_so_far};
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: result item with no access pending: hit=%0b hits=%0d misses=%0d",
                             $time, seen.hit, seen.hits, seen.misses);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (seen.hit !== want.hit)
                    begin
                        $display("%0t: is_hit expected %0b, got %0b", $time, want.hit, seen.hit);
                        mismatch_count++;
                    end
                    if (seen.hits !== want.hits)
                    begin
                        $display("%0t: hits_so_far expected %0d, got %0d",
                                 $time, want.hits, seen.hits);
                        mismatch_count++;
                    end
                    if (seen.misses !== want.misses)
                    begin
                        $display("%0t: misses_so_far expected %0d, got %0d",
                                 $time, want.misses, seen.misses);
                        mismatch_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (dmc_reg_t'(paddr[2]))
                    REG_BLOCK_BYTES: block_bytes_reg = pwdata[BLOCK_BYTES_W-1:0];
                    REG_SET_COUNT:   set_count_reg   = pwdata[SET_COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (access_valid && !access_stall)
            begin
                if (new_run)
                begin
                    line_valid = '0;
                    hit_total  = '0;
                    miss_total = '0;
                end
                divisor = block_bytes_reg;
                if (divisor == 0)
                    divisor = 1;
                sets = set_count_reg;
                if (sets == 0)
                    sets = 1;
                else if (sets > MAX_SETS_DEF)
                    sets = MAX_SETS_DEF;
                block_num = access_address / divisor;
                index     = block_num % sets;
                hit       = line_valid[index] && (tag_mem[index] == block_num);
                if (hit)
                    hit_total = hit_total + 64'd1;
                else
                begin
                    miss_total        = miss_total + 64'd1;
                    tag_mem[index]    = block_num;
                    line_valid[index] = 1'b1;
                end
                want.hit    = hit;
                want.hits   = hit_total;
                want.misses = miss_total;
                expected_lookups.push_back(want);
            end
            pending_lookups = expected_lookups.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the direct-mapped cache hit counter: reset, register
// writes, access items under several idling patterns, and the verdict.
// Depends on dmc_pkg, direct_mapped_cache_hit_counter_core and dmc_hit_checker.
module tb;
    import dmc_pkg::*;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     psel           = 1'b0;
    logic                     penable        = 1'b0;
    logic                     pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr          = '0;
    logic [APB_DATA_W-1:0]    pwdata         = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     access_valid   = 1'b0;
    logic                     access_stall;
    logic [31:0]              access_address = '0;
    logic                     new_run        = 1'b0;
    logic                     result_valid;
    logic                     result_stall   = 1'b0;
    logic                     is_hit;
    logic [63:0]              hits_so_far;
    logic [63:0]              misses_so_far;
    int                       mismatch_count;
    int                       pending_lookups;
    int                       sender_idle_pct    = 0;
    int                       receiver_stall_pct = 0;
    logic [BLOCK_BYTES_W-1:0] cur_block_bytes    = BLOCK_BYTES_RST;
    logic [SET_COUNT_W-1:0]   cur_set_count      = SET_COUNT_RST;
    logic [31:0]              hot_addr [8];

    direct_mapped_cache_hit_counter_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .access_valid   (access_valid),
        .access_stall   (access_stall),
        .access_address (access_address),
        .new_run        (new_run),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .is_hit         (is_hit),
        .hits_so_far    (hits_so_far),
        .misses_so_far  (misses_so_far)
    );

    dmc_hit_checker hit_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .access_valid    (access_valid),
        .access_stall    (access_stall),
        .access_address  (access_address),
        .new_run         (new_run),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .is_hit          (is_hit),
        .hits_so_far     (hits_so_far),
        .misses_so_far   (misses_so_far),
        .mismatch_count  (mismatch_count),
        .pending_lookups (pending_lookups)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    initial
    begin
        #4ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input dmc_reg_t r, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({r, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [BLOCK_BYTES_W-1:0] bytes_val,
                             input logic [SET_COUNT_W-1:0] sets_val);
        write_reg(REG_BLOCK_BYTES, {15'($urandom), bytes_val});
        write_reg(REG_SET_COUNT, {22'($urandom), sets_val});
        cur_block_bytes = bytes_val;
        cur_set_count   = sets_val;
    endtask

    task automatic send_access(input logic [31:0] addr, input logic clear_first);
        bit idle_now;
        idle_now = ($urandom_range(0, 99) < sender_idle_pct);
        if (idle_now)
            access_valid <= 1'b0;
        while (idle_now)
        begin
            @(negedge clk);
            idle_now = ($urandom_range(0, 99) < sender_idle_pct);
        end
        access_valid   <= 1'b1;
        access_address <= addr;
        new_run        <= clear_first;
        @(posedge clk);
        while (access_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        access_valid <= 1'b0;
        new_run      <= 1'b0;
        do
            @(negedge clk);
        while (pending_lookups != 0);
    endtask

    function automatic logic [31:0] pick_address();
        int          kind;
        int          k;
        logic [31:0] bytes_eff;
        logic [31:0] sets_eff;
        logic [31:0] addr;
        bytes_eff = (cur_block_bytes == 0) ? 32'd1 : 32'(cur_block_bytes);
        sets_eff  = (cur_set_count == 0) ? 32'd1 :
                    (cur_set_count > MAX_SETS_DEF) ? 32'(MAX_SETS_DEF) : 32'(cur_set_count);
        kind = $urandom_range(0, 99);
        k    = $urandom_range(0, 7);
        if (kind < 55)
            addr = hot_addr[k] + $urandom_range(0, 31);
        else if (kind < 70)
            addr = hot_addr[k] + bytes_eff * sets_eff * $urandom_range(1, 3);
        else
        begin
            addr = $urandom;
            if ($urandom_range(0, 3) == 0)
                hot_addr[k] = addr;
        end
        return addr;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_000F, 1'b0);
        send_access(32'h0000_0010, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'hFFFF_FFF0, 1'b0);
        send_access(32'h0000_2000, 1'b0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0004, 1'b0);
        send_access(32'h8000_0000, 1'b0);
        send_access(32'h7FFF_FFFF, 1'b0);
        drain();
        configure(17'd0, 10'd0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0001, 1'b0);
        send_access(32'h0000_0001, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b0);
        drain();
        configure(17'h1FFFF, 10'h3FF);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'hFFFE_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        drain();
        configure(17'd65536, 10'd512);
        send_access(32'h1234_5678, 1'b0);
        send_access(32'h1234_FFFF, 1'b0);
        send_access(32'h9234_5678, 1'b0);
        send_access(32'h1234_0000, 1'b0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 68;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 68;
                end
                default:
                begin
                    sender_idle_pct    = 15;
                    receiver_stall_pct = 15;
                end
            endcase
            case (p)
                0: configure(17'd16, 10'd512);
                1: configure(17'd1, 10'd1);
                2: configure(17'd0, 10'd0);
                3: configure(17'd65536, 10'd512);
                4: configure(17'h1FFFF, 10'h3FF);
                5: configure(17'd4, 10'd8);
                6: configure(17'd256, 10'd37);
                default: configure(17'($urandom_range(1, 65536)), 10'($urandom_range(1, 512)));
            endcase
            foreach (hot_addr[i])
                hot_addr[i] = $urandom;
            for (int n = 0; n < 216; n++)
                send_access(pick_address(), $urandom_range(0, 39) == 0);
            drain();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        drain();
        repeat (100) @(negedge clk);
        if (mismatch_count == 0 && pending_lookups == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
